/* hdl/simon_pkg.sv */
package simon_pkg;

	localparam int KEY_WORDS     = 4;
	localparam int WORD_W        = 32;
	localparam int ROUND_COUNT_W = 6;
	localparam int CFG_IDX_W     = 3;
	localparam int SEQ_LEN       = 62;
	localparam int SEQ_IDX_W     = 6;

	// z3 sequence, leftmost digit of the published string is index 0
	localparam logic [SEQ_LEN-1:0] Z3_SEQ      = 62'h36EB19781229CD0F;
	localparam logic [WORD_W-1:0]  ROUND_CONST = 32'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 3'd4;

	// operation codes on the cmd field
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_words_t;

	// command bundle from controller to datapath
	typedef struct packed {
		logic       win_load;
		logic       exp_we;
		logic       exp_from_key;
		logic [1:0] key_sel;
		logic       z_bit;
		logic       blk_load;
		logic       round_en;
		logic       decrypt;
		logic       out_load;
	} simon_cmd_t;

	function automatic logic z3_bit(input logic [SEQ_IDX_W-1:0] idx);
		logic [SEQ_IDX_W-1:0] p;
		p = (idx >= SEQ_IDX_W'(SEQ_LEN)) ? idx - SEQ_IDX_W'(SEQ_LEN) : idx;
		return Z3_SEQ[SEQ_IDX_W'(SEQ_LEN - 1) - p];
	endfunction

endpackage

/* hdl/simon_ram.sv */
module simon_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 44
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* hdl/simon_dp.sv */
module simon_dp (
	input  logic                       clk,
	input  simon_pkg::simon_cmd_t      cmd_bus,
	input  simon_pkg::key_words_t      key_words,
	input  logic [31:0]                word_x,
	input  logic [31:0]                word_y,
	input  logic [31:0]                rkey,
	output logic [31:0]                exp_wdata,
	output logic [31:0]                out_x,
	output logic [31:0]                out_y
);
	import simon_pkg::*;

	logic [WORD_W-1:0] win_q [KEY_WORDS];
	logic [WORD_W-1:0] x_q, y_q, out_x_q, out_y_q;
	logic [WORD_W-1:0] t_a, t_b, new_key, mix_x, mix_y;

	function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
		return ({v[WORD_W-2:0], v[WORD_W-1]} & {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]})
			^ {v[WORD_W-3:0], v[WORD_W-1:WORD_W-2]};
	endfunction

	// next round key from the sliding window k[i-4..i-1]
	always_comb begin
		t_a     = {win_q[3][2:0], win_q[3][WORD_W-1:3]} ^ win_q[1];
		t_b     = t_a ^ {t_a[0], t_a[WORD_W-1:1]};
		new_key = ~win_q[0] ^ t_b ^ {{(WORD_W-1){1'b0}}, cmd_bus.z_bit} ^ ROUND_CONST;
		mix_x   = mix(x_q);
		mix_y   = mix(y_q);
	end

	assign exp_wdata = cmd_bus.exp_from_key ? key_words[cmd_bus.key_sel] : new_key;

	always_ff @(posedge clk) begin
		if (cmd_bus.win_load) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				win_q[i] <= key_words[i];
			end
		end else if (cmd_bus.exp_we && !cmd_bus.exp_from_key) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= new_key;
		end

		if (cmd_bus.blk_load) begin
			x_q <= word_x;
			y_q <= word_y;
		end else if (cmd_bus.round_en) begin
			if (cmd_bus.decrypt) begin
				y_q <= x_q ^ mix_y ^ rkey;
				x_q <= y_q;
			end else begin
				x_q <= y_q ^ mix_x ^ rkey;
				y_q <= x_q;
			end
		end

		if (cmd_bus.out_load) begin
			out_x_q <= x_q;
			out_y_q <= y_q;
		end
	end

	assign out_x = out_x_q;
	assign out_y = out_y_q;
endmodule

/* hdl/simon_ctrl.sv */
module simon_ctrl #(
	parameter int MAX_ROUNDS = 44
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          key_wr,
	input  logic [5:0]                    round_count,
	input  logic                          in_valid,
	input  logic                          in_cmd,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output simon_pkg::simon_cmd_t         cmd_bus,
	output logic                          ram_we,
	output logic [$clog2(MAX_ROUNDS)-1:0] ram_waddr,
	output logic [$clog2(MAX_ROUNDS)-1:0] ram_raddr
);
	import simon_pkg::*;

	localparam int AW = $clog2(MAX_ROUNDS);
	localparam int NW = $clog2(MAX_ROUNDS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_ROUND, ST_DONE} state_t;

	state_t          state_q;
	logic            kick_q, dec_q, out_valid_q;
	logic [AW-1:0]   cnt_q, addr_q, start_addr, step_addr;
	logic [NW-1:0]   left_q, n_eff;
	logic            accept, last, slot_free;

	always_comb begin
		n_eff = ((ROUND_COUNT_W+1)'(round_count) > (ROUND_COUNT_W+1)'(MAX_ROUNDS))
			? NW'(MAX_ROUNDS) : NW'(round_count);
		in_ready   = (state_q == ST_IDLE) && !kick_q;
		accept     = in_valid && in_ready;
		start_addr = (in_cmd == CMD_DECRYPT) ? AW'(n_eff - NW'(1)) : '0;
		last       = (left_q == NW'(1));
		step_addr  = last ? addr_q : (dec_q ? addr_q - AW'(1) : addr_q + AW'(1));
		ram_raddr  = accept ? start_addr : step_addr;
		slot_free  = !out_valid_q || out_ready;

		ram_we    = (state_q == ST_EXPAND) && !kick_q;
		ram_waddr = cnt_q;

		cmd_bus.win_load     = kick_q && (state_q == ST_IDLE || state_q == ST_EXPAND);
		cmd_bus.exp_we       = ram_we;
		cmd_bus.exp_from_key = ({1'b0, cnt_q} < (AW+1)'(KEY_WORDS));
		cmd_bus.key_sel      = cnt_q[1:0];
		cmd_bus.z_bit        = z3_bit(SEQ_IDX_W'(cnt_q - AW'(KEY_WORDS)));
		cmd_bus.blk_load     = accept;
		cmd_bus.round_en     = (state_q == ST_ROUND);
		cmd_bus.decrypt      = dec_q;
		cmd_bus.out_load     = (state_q == ST_DONE) && slot_free;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kick_q      <= 1'b1;
			dec_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			addr_q      <= '0;
			left_q      <= '0;
		end else begin
			kick_q <= key_wr;

			if (cmd_bus.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (kick_q) begin
						state_q <= ST_EXPAND;
						cnt_q   <= '0;
					end else if (accept) begin
						dec_q   <= (in_cmd == CMD_DECRYPT);
						addr_q  <= start_addr;
						left_q  <= n_eff;
						state_q <= (n_eff == '0) ? ST_DONE : ST_ROUND;
					end
				end
				ST_EXPAND: begin
					if (kick_q) begin
						cnt_q <= '0;
					end else if (cnt_q == AW'(MAX_ROUNDS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_ROUND: begin
					left_q <= left_q - NW'(1);
					addr_q <= step_addr;
					if (last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_last_round_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && last) |=> (state_q == ST_DONE))
		else $error("last round did not finish the block");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ROUND || state_q == ST_DONE))
		else $error("accepted block did not start");
	a_no_key_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !in_ready)
		else $error("input taken while key schedule runs");
	a_round_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |->
			(left_q != '0 && {1'b0, addr_q} < (AW+1)'(MAX_ROUNDS)))
		else $error("round counter or key address out of range");
`endif
endmodule

/* hdl/simon_block_cipher.sv */
// SIMON 64/128 block cipher, one 64-bit block (word_x, word_y) per input transaction,
// cmd 0 encrypts and cmd 1 decrypts over round_count rounds (values above MAX_ROUNDS
// saturate, zero passes the block through). Key words 0..3 and round_count are written
// through the cfg port at indexes 0..4; other indexes are ignored. After reset and after
// every key word write the round keys are expanded into a MAX_ROUNDS-deep RAM, one key
// per cycle, while in_ready stays low. Cfg writes are always taken; the user must write
// key words only while no block is in flight, as the block itself does not enforce it.
// With n the saturated round count, the accepting edge loads the block and fetches the
// first round key, then the n rounds run (one round key read per cycle from the key RAM
// is the limit) and the result is loaded into the output register once the output slot
// is free. The next block is accepted only after that hand-off; the output register
// lets the next block be accepted while a result still waits to be taken.
module simon_block_cipher #(
	parameter int MAX_ROUNDS = 44
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input block channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [31:0] word_x,
	input  logic [31:0] word_y,
	// result block channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_x,
	output logic [31:0] out_y
);
	import simon_pkg::*;

	localparam int AW = $clog2(MAX_ROUNDS);

	key_words_t                 key_q;
	logic [ROUND_COUNT_W-1:0]   round_count_q;
	logic                       cfg_wr, key_wr;
	simon_cmd_t                 cmd_bus;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [WORD_W-1:0]          ram_wdata, ram_rdata;

	// config writes are always accepted
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	// a key word write restarts the key schedule unless a block is in flight
	assign key_wr    = cfg_wr && (cfg_index <= REG_KEY_WORD_3);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q         <= '0;
			round_count_q <= ROUND_COUNT_W'(44);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_KEY_WORD_0:  key_q[0] <= cfg_data;
				REG_KEY_WORD_1:  key_q[1] <= cfg_data;
				REG_KEY_WORD_2:  key_q[2] <= cfg_data;
				REG_KEY_WORD_3:  key_q[3] <= cfg_data;
				REG_ROUND_COUNT: round_count_q <= cfg_data[ROUND_COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: key expansion sweep, round count, key addressing, output handoff
	simon_ctrl #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_wr     (key_wr),
		.round_count(round_count_q),
		.in_valid   (in_valid),
		.in_cmd     (cmd),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd_bus    (cmd_bus),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_raddr  (ram_raddr)
	);

	// round function, key schedule window and output register
	simon_dp u_dp (
		.clk      (clk),
		.cmd_bus  (cmd_bus),
		.key_words(key_q),
		.word_x   (word_x),
		.word_y   (word_y),
		.rkey     (ram_rdata),
		.exp_wdata(ram_wdata),
		.out_x    (out_x),
		.out_y    (out_y)
	);

	// round key store, registered read
	simon_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_ROUNDS)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	import simon_pkg::*;

	localparam int MAX_ROUNDS = 44;
	// run ends as a failure if it goes past this many cycles
	localparam int CYCLE_LIMIT = 1_000_000;
	// idle cycles run after the last result before the final check
	localparam int TAIL_CYCLES = MAX_ROUNDS + 16;

	// register indexes past the last defined one, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	// z3 sequence, leftmost digit is index 0
	localparam logic [61:0] Z3_BITS = 62'h36EB19781229CD0F;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} block_t;

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// dut ports, all inputs start at known values
	// ------------------------------------------------------------------
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 cmd       = CMD_ENCRYPT;
	logic [31:0]          word_x    = '0;
	logic [31:0]          word_y    = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [31:0]          out_x;
	logic [31:0]          out_y;

	simon_block_cipher #(
		.MAX_ROUNDS(MAX_ROUNDS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.word_x   (word_x),
		.word_y   (word_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x    (out_x),
		.out_y    (out_y)
	);

	// ------------------------------------------------------------------
	// cipher model: shadow registers and expanded round keys
	// ------------------------------------------------------------------
	logic [31:0]              key_shadow [KEY_WORDS];
	logic [ROUND_COUNT_W-1:0] rounds_shadow;
	logic [31:0]              round_keys [MAX_ROUNDS];

	block_t expected_blocks [$];
	int     err_count  = 0;
	int     cycle_cnt  = 0;
	int     rx_stall   = 0;
	bit     no_idle    = 1'b0;

	function automatic logic [31:0] rotl(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [31:0] rotr(logic [31:0] v, int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	function automatic logic [31:0] round_mix(logic [31:0] v);
		return (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
	endfunction

	// round keys 0..3 are the key words, the rest follow the published schedule
	function automatic void expand_round_keys();
		logic [31:0] t;
		for (int i = 0; i < KEY_WORDS; i++)
			round_keys[i] = key_shadow[i];
		for (int i = KEY_WORDS; i < MAX_ROUNDS; i++) begin
			t = rotr(round_keys[i-1], 3) ^ round_keys[i-3];
			t = t ^ rotr(t, 1);
			round_keys[i] = ~round_keys[i-4] ^ t
				^ {31'b0, Z3_BITS[61 - ((i - KEY_WORDS) % SEQ_LEN)]} ^ 32'd3;
		end
	endfunction

	// full block transform at the current round count
	function automatic block_t simon_transform(logic op, logic [31:0] x, logic [31:0] y);
		logic [31:0] t;
		int          n;
		block_t      res;
		// counts above the key store depth saturate, zero passes the block through
		n = (rounds_shadow > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_shadow);
		if (op == CMD_ENCRYPT) begin
			for (int i = 0; i < n; i++) begin
				t = x;
				x = y ^ round_mix(x) ^ round_keys[i];
				y = t;
			end
		end else begin
			for (int i = n; i > 0; i--) begin
				t = y;
				y = x ^ round_mix(y) ^ round_keys[i-1];
				x = t;
			end
		end
		res.x = x;
		res.y = y;
		return res;
	endfunction

	// idle length: mostly none or short, now and then long, none at all while no_idle is set
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// ------------------------------------------------------------------
	// shared drivers
	// ------------------------------------------------------------------

	// one block transaction; valid stays high into the next call when no gap
	task automatic send_block(logic op, logic [31:0] x, logic [31:0] y);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		word_x   <= x;
		word_y   <= y;
		do @(posedge clk); while (!in_ready);
		// accepted at this edge, config cannot change while blocks are in flight
		expected_blocks.insert(expected_blocks.size(), simon_transform(op, x, y));
	endtask

	// sender holds off until every outstanding result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_blocks.size() != 0);
	endtask

	// one register write transaction, called only while the block is idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx < KEY_WORDS) begin
			key_shadow[idx] = data;
			expand_round_keys();
		end else if (idx == REG_ROUND_COUNT) begin
			rounds_shadow = data[ROUND_COUNT_W-1:0];
		end
		@(posedge clk);
	endtask

	task automatic write_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
			logic [31:0] k3);
		write_reg(REG_KEY_WORD_0, k0);
		write_reg(REG_KEY_WORD_1, k1);
		write_reg(REG_KEY_WORD_2, k2);
		write_reg(REG_KEY_WORD_3, k3);
	endtask

	// round count with random upper data bits, only the low six count
	task automatic write_rounds(logic [ROUND_COUNT_W-1:0] n);
		logic [31:0] data;
		data = $urandom();
		data[ROUND_COUNT_W-1:0] = n;
		write_reg(REG_ROUND_COUNT, data);
	endtask

	// ------------------------------------------------------------------
	// result side: random back-pressure and in-order compare
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		block_t want;
		int     gap;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					$error("result transaction with nothing outstanding: out_x %h out_y %h",
						out_x, out_y);
					err_count++;
				end else begin
					want = expected_blocks.pop_front();
					if (out_x !== want.x) begin
						$error("out_x mismatch: expected %h actual %h", want.x, out_x);
						err_count++;
					end
					if (out_y !== want.y) begin
						$error("out_y mismatch: expected %h actual %h", want.y, out_y);
						err_count++;
					end
				end
			end
			// stall runs count down, new ones drawn from the shared gap mix
			if (rx_stall != 0) begin
				out_ready <= 1'b0;
				rx_stall--;
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					rx_stall = gap - 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// all-zero key and full rounds straight out of reset
	task automatic test_reset_key();
		send_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_results();
	endtask

	// published 64/128 key and plaintext, then decrypt the ciphertext back
	task automatic test_published_vector();
		block_t ct;
		write_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918);
		write_rounds(6'd44);
		ct = simon_transform(CMD_ENCRYPT, 32'h656b_696c, 32'h2064_6e75);
		send_block(CMD_ENCRYPT, 32'h656b_696c, 32'h2064_6e75);
		send_block(CMD_DECRYPT, ct.x, ct.y);
		drain_results();
	endtask

	// extreme block halves both ways
	task automatic test_word_extremes();
		send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_block(CMD_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
		send_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
		send_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
		send_block(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
		drain_results();
	endtask

	// zero rounds passes through, one round, full depth, and saturating counts
	task automatic test_round_count_limits();
		logic [ROUND_COUNT_W-1:0] counts [5];
		counts = '{6'd0, 6'd1, 6'd44, 6'd45, 6'd63};
		foreach (counts[i]) begin
			write_rounds(counts[i]);
			send_block(CMD_ENCRYPT, $urandom(), $urandom());
			send_block(CMD_DECRYPT, $urandom(), $urandom());
			drain_results();
		end
	endtask

	// writes to undefined indexes must leave key and round count alone
	task automatic test_spare_indexes();
		write_rounds(6'd44);
		for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
			write_reg(CFG_IDX_W'(i), $urandom());
		send_block(CMD_ENCRYPT, $urandom(), $urandom());
		send_block(CMD_DECRYPT, $urandom(), $urandom());
		drain_results();
	endtask

	// random key and round count for one phase
	task automatic random_config();
		int r;
		if ($urandom_range(0, 9) < 7)
			write_key($urandom(), $urandom(), $urandom(), $urandom());
		else
			write_reg(CFG_IDX_W'($urandom_range(0, KEY_WORDS - 1)), $urandom());
		r = $urandom_range(0, 19);
		if (r == 0)
			write_rounds(6'd0);
		else if (r == 1)
			write_rounds(6'd1);
		else if (r < 5)
			write_rounds(6'd44);
		else if (r < 7)
			write_rounds(ROUND_COUNT_W'($urandom_range(45, 63)));
		else
			write_rounds(ROUND_COUNT_W'($urandom_range(1, 44)));
	endtask

	// random blocks, part of them decrypting the previous ciphertext
	task automatic random_blocks(int count);
		block_t prev;
		logic   prev_valid;
		prev_valid = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (prev_valid && $urandom_range(0, 3) == 0) begin
				send_block(CMD_DECRYPT, prev.x, prev.y);
				prev_valid = 1'b0;
			end else if ($urandom_range(0, 1) == 0) begin
				prev.x = $urandom();
				prev.y = $urandom();
				send_block(CMD_ENCRYPT, prev.x, prev.y);
				prev = simon_transform(CMD_ENCRYPT, prev.x, prev.y);
				prev_valid = 1'b1;
			end else begin
				send_block(CMD_DECRYPT, $urandom(), $urandom());
			end
		end
	endtask

	// phases of random traffic, idle between phases for new config
	task automatic test_random_traffic();
		for (int phase = 0; phase < 18; phase++) begin
			random_config();
			random_blocks(50);
			drain_results();
		end
	endtask

	// back-to-back stretch with neither side idling
	task automatic test_quiet_stream();
		random_config();
		no_idle = 1'b1;
		random_blocks(50);
		drain_results();
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < KEY_WORDS; i++)
			key_shadow[i] = '0;
		rounds_shadow = 6'd44;
		expand_round_keys();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_published_vector();
		test_word_extremes();
		test_round_count_limits();
		test_spare_indexes();
		test_random_traffic();
		test_quiet_stream();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_blocks.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
